// ===== hw/rtl/cbpe_pkg.sv =====
// Shared types and constants of the cubic Bezier point evaluator.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package cbpe_pkg;

  // Field sizes
  localparam int COORD_W  = 16;                 // control point coordinate
  localparam int T_FRAC   = 16;                 // fraction bits of t
  localparam int T_W      = T_FRAC + 1;         // t in [0, 2.0), values above 1.0 clamp to 1.0
  localparam int OUT_W    = 20;                 // Q16.4 result
  localparam int OUT_FRAC = 4;

  // Internal widths
  localparam int SQ_W     = 2 * T_FRAC + 1;     // t^2, t*s, s^2
  localparam int CUBE_W   = SQ_W + T_W;         // raw third-order product
  localparam int WT_W     = 3 * T_FRAC + 1;     // Bernstein weight, sum is 2^(3F)
  localparam int PROD_W   = WT_W + COORD_W;     // weight times biased coordinate
  localparam int ACC_W    = PROD_W + 1;         // four products plus rounding half
  localparam int RND_SHIFT = 3 * T_FRAC - OUT_FRAC;
  localparam int Q_W      = ACC_W - RND_SHIFT;

  localparam logic [T_W-1:0]   T_ONE   = T_W'(1) << T_FRAC;
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SHIFT - 1);
  // Bias added to every coordinate, expressed in the Q16.4 output scale
  localparam logic [OUT_W-1:0] OUT_OFS = OUT_W'(1) << (COORD_W - 1 + OUT_FRAC);

  typedef logic [COORD_W-1:0] cbpe_coord_t;
  typedef cbpe_coord_t [3:0] cbpe_quad_t;

  // Input transaction
  typedef struct packed {
    logic signed [COORD_W-1:0] ctrl_x0;
    logic signed [COORD_W-1:0] ctrl_y0;
    logic signed [COORD_W-1:0] ctrl_x1;
    logic signed [COORD_W-1:0] ctrl_y1;
    logic signed [COORD_W-1:0] ctrl_x2;
    logic signed [COORD_W-1:0] ctrl_y2;
    logic signed [COORD_W-1:0] ctrl_x3;
    logic signed [COORD_W-1:0] ctrl_y3;
    logic        [T_W-1:0]     param_t;
  } cbpe_in_t;

  // Result transaction
  typedef struct packed {
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
  } cbpe_out_t;

  // Four Bernstein weights, index 0 pairs with the first control point
  typedef struct packed {
    logic [3:0][WT_W-1:0] w;
  } cbpe_wts_t;

  // Offset a signed coordinate into an unsigned one by flipping its sign bit
  function automatic cbpe_coord_t bias_coord(input logic [COORD_W-1:0] p);
    return {~p[COORD_W-1], p[COORD_W-2:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cbpe_weight.sv =====
// Two-stage Bernstein weight generator: squares, then cubes scaled by 1,3,3,1.
// Depends on cbpe_pkg.
`default_nettype none

module cbpe_weight (
  input  wire logic                 clk,
  input  wire logic [cbpe_pkg::T_W-1:0] t,
  input  wire logic [cbpe_pkg::T_W-1:0] s,
  output cbpe_pkg::cbpe_wts_t       wts
);
  import cbpe_pkg::*;

  logic [T_W-1:0]  t1;
  logic [T_W-1:0]  s1;
  logic [SQ_W-1:0] tt;
  logic [SQ_W-1:0] ts;
  logic [SQ_W-1:0] ss;

  logic [CUBE_W-1:0] p_sss;
  logic [CUBE_W-1:0] p_tss;
  logic [CUBE_W-1:0] p_tts;
  logic [CUBE_W-1:0] p_ttt;
  logic [CUBE_W-1:0] p_tss3;
  logic [CUBE_W-1:0] p_tts3;

  // Stage 1: second-order products
  always_ff @(posedge clk) begin
    t1 <= t;
    s1 <= s;
    tt <= SQ_W'(t) * SQ_W'(t);
    ts <= SQ_W'(t) * SQ_W'(s);
    ss <= SQ_W'(s) * SQ_W'(s);
  end

  // Third-order products; middle terms take the factor of three by shift and add
  always_comb begin
    p_sss  = CUBE_W'(ss) * CUBE_W'(s1);
    p_tss  = CUBE_W'(ts) * CUBE_W'(s1);
    p_tts  = CUBE_W'(ts) * CUBE_W'(t1);
    p_ttt  = CUBE_W'(tt) * CUBE_W'(t1);
    p_tss3 = CUBE_W'((p_tss << 1) + p_tss);
    p_tts3 = CUBE_W'((p_tts << 1) + p_tts);
  end

  // Stage 2: weights
  always_ff @(posedge clk) begin
    wts.w[0] <= p_sss[WT_W-1:0];
    wts.w[1] <= p_tss3[WT_W-1:0];
    wts.w[2] <= p_tts3[WT_W-1:0];
    wts.w[3] <= p_ttt[WT_W-1:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cbpe_axis.sv =====
// Three-stage weighted sum for one axis: products, pair sums, round and unbias.
// Depends on cbpe_pkg.
`default_nettype none

module cbpe_axis (
  input  wire logic                       clk,
  input  wire cbpe_pkg::cbpe_wts_t        wts,
  input  wire cbpe_pkg::cbpe_quad_t       u,
  output logic signed [cbpe_pkg::OUT_W-1:0] point
);
  import cbpe_pkg::*;

  logic [3:0][PROD_W-1:0] prod;
  logic [ACC_W-1:0]       sum01;
  logic [ACC_W-1:0]       sum23;
  logic [ACC_W-1:0]       acc;
  logic [Q_W-1:0]         q;

  // Stage 3: weight times biased coordinate, four independent multipliers
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod[i] <= PROD_W'(wts.w[i]) * PROD_W'(u[i]);
    end
  end

  // Stage 4: pair sums, rounding half folded into the second pair
  always_ff @(posedge clk) begin
    sum01 <= ACC_W'(prod[0]) + ACC_W'(prod[1]);
    sum23 <= ACC_W'(prod[2]) + ACC_W'(prod[3]) + RND_HALF;
  end

  // Final sum, drop fraction bits below Q16.4
  always_comb begin
    acc = sum01 + sum23;
    q   = acc[ACC_W-1:RND_SHIFT];
  end

  // Stage 5: remove coordinate bias, wrap to output width
  always_ff @(posedge clk) begin
    point <= signed'(q[OUT_W-1:0] - OUT_OFS);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cubic_bezier_point_eval.sv =====
// Cubic Bezier point evaluator: a fully pipelined datapath that accepts one
// transaction per clock. Start is taken at any edge (busy is always low) and
// the matching result appears on result with done high after six register
// stages; results leave in the order transactions came in. The stages are
// input capture, two stages of weight generation (t^2 terms, then cubes),
// the coordinate multipliers, pair sums, and the final add with rounding and
// unbias. A t above 1.0 is treated as 1.0. The receiver cannot stall, so
// done must be sampled in the cycle it is high.
// Depends on cbpe_pkg, cbpe_weight and cbpe_axis.
`default_nettype none

module cubic_bezier_point_eval (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire cbpe_pkg::cbpe_in_t item,
  output logic                done,
  output cbpe_pkg::cbpe_out_t result
);
  import cbpe_pkg::*;

  localparam int N_STAGES = 6;

  logic [N_STAGES-1:0] vld;
  logic [T_W-1:0]      t_clamp;
  logic [T_W-1:0]      t0;
  logic [T_W-1:0]      s0;
  cbpe_quad_t          ux0, ux1, ux2;
  cbpe_quad_t          uy0, uy1, uy2;
  cbpe_wts_t           wts;
  logic signed [OUT_W-1:0] px;
  logic signed [OUT_W-1:0] py;

  // Fully pipelined, never refuses a transaction
  assign busy = 1'b0;

  // Saturate t at 1.0
  always_comb begin
    t_clamp = (item.param_t > T_ONE) ? T_ONE : item.param_t;
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[N_STAGES-2:0], start & ~busy};
    end
  end

  // Stage 0: capture t, 1-t and biased coordinates
  always_ff @(posedge clk) begin
    t0     <= t_clamp;
    s0     <= T_ONE - t_clamp;
    ux0[0] <= bias_coord(item.ctrl_x0);
    ux0[1] <= bias_coord(item.ctrl_x1);
    ux0[2] <= bias_coord(item.ctrl_x2);
    ux0[3] <= bias_coord(item.ctrl_x3);
    uy0[0] <= bias_coord(item.ctrl_y0);
    uy0[1] <= bias_coord(item.ctrl_y1);
    uy0[2] <= bias_coord(item.ctrl_y2);
    uy0[3] <= bias_coord(item.ctrl_y3);
  end

  // Hold coordinates until the weights are ready
  always_ff @(posedge clk) begin
    ux1 <= ux0;
    uy1 <= uy0;
    ux2 <= ux1;
    uy2 <= uy1;
  end

  cbpe_weight u_weight (
    .clk (clk),
    .t   (t0),
    .s   (s0),
    .wts (wts)
  );

  cbpe_axis u_axis_x (
    .clk   (clk),
    .wts   (wts),
    .u     (ux2),
    .point (px)
  );

  cbpe_axis u_axis_y (
    .clk   (clk),
    .wts   (wts),
    .u     (uy2),
    .point (py)
  );

  // Drive the result transaction
  assign done           = vld[N_STAGES-1];
  assign result.point_x = px;
  assign result.point_y = py;

endmodule

`default_nettype wire

// ===== test/cubic_bezier_point_eval_tb.sv =====
// Testbench for cubic_bezier_point_eval: drives control points and t, predicts
// each curve point in exact wide integer arithmetic and checks every result.
// Depends on cbpe_pkg and the cubic_bezier_point_eval RTL.
`timescale 1ns / 100ps

module cubic_bezier_point_eval_tb;
  import cbpe_pkg::*;

  // Predicted curve points in flight, plus the checks made on arrivals
  class curve_point_board;
    localparam int SHIFT = 3 * T_FRAC - OUT_FRAC;

    cbpe_out_t pending_points[$];
    int unsigned noted;
    int unsigned checked;
    int unsigned errors;

    // Exact Bernstein sum for one axis, rounded half up to Q16.4
    function logic [OUT_W-1:0] axis_point(input cbpe_quad_t pts,
                                          input logic [T_W-1:0] t_in);
      logic [T_W-1:0] t;
      logic [T_W-1:0] s;
      logic [79:0] wt [4];
      logic [79:0] acc;
      logic [79:0] q;
      t = t_in;
      // Clamp t above 1.0
      if (t > T_ONE) t = T_ONE;
      s = T_ONE - t;
      wt[0] = 80'(s) * 80'(s) * 80'(s);
      wt[1] = 80'(3) * 80'(t) * 80'(s) * 80'(s);
      wt[2] = 80'(3) * 80'(t) * 80'(t) * 80'(s);
      wt[3] = 80'(t) * 80'(t) * 80'(t);
      acc = 80'(1) << (SHIFT - 1);
      // Offset each coordinate to unsigned so all products stay positive
      for (int i = 0; i < 4; i++) begin
        acc = acc + wt[i] * 80'(pts[i] ^ (COORD_W'(1) << (COORD_W - 1)));
      end
      q = (acc >> SHIFT) - (80'(1) << (COORD_W - 1 + OUT_FRAC));
      return q[OUT_W-1:0];
    endfunction

    function void note(input cbpe_in_t it);
      cbpe_out_t pt;
      pt.point_x = axis_point({it.ctrl_x3, it.ctrl_x2, it.ctrl_x1, it.ctrl_x0},
                              it.param_t);
      pt.point_y = axis_point({it.ctrl_y3, it.ctrl_y2, it.ctrl_y1, it.ctrl_y0},
                              it.param_t);
      pending_points.push_back(pt);
      noted++;
    endfunction

    function void check(input cbpe_out_t got);
      cbpe_out_t exp_pt;
      if (pending_points.size() == 0) begin
        $error("point (%0d, %0d) arrived with no transaction outstanding",
               $signed(got.point_x), $signed(got.point_y));
        errors++;
        return;
      end
      exp_pt = pending_points.pop_front();
      checked++;
      if (got.point_x !== exp_pt.point_x) begin
        $error("point_x: expected %0d, got %0d",
               $signed(exp_pt.point_x), $signed(got.point_x));
        errors++;
      end
      if (got.point_y !== exp_pt.point_y) begin
        $error("point_y: expected %0d, got %0d",
               $signed(exp_pt.point_y), $signed(got.point_y));
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  cbpe_in_t  item = '0;
  logic      done;
  cbpe_out_t result;

  curve_point_board board = new();

  cubic_bezier_point_eval uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #2 clk = ~clk;

  // Check every result in the cycle its strobe is high
  always @(posedge clk) begin
    if (!rst && done) board.check(result);
  end

  // End the run with an error message if it hangs
  initial begin
    #400000;
    $display("cubic_bezier_point_eval_tb: errors");
    $finish;
  end

  // Offer one transaction after a random gap; call and return at a falling edge
  task automatic send_item(input cbpe_in_t it, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note(it);
    @(negedge clk);
  endtask

  function automatic cbpe_in_t make_item(input int x0, y0, x1, y1, x2, y2, x3, y3,
                                         input int t);
    cbpe_in_t it;
    it.ctrl_x0 = COORD_W'(x0);
    it.ctrl_y0 = COORD_W'(y0);
    it.ctrl_x1 = COORD_W'(x1);
    it.ctrl_y1 = COORD_W'(y1);
    it.ctrl_x2 = COORD_W'(x2);
    it.ctrl_y2 = COORD_W'(y2);
    it.ctrl_x3 = COORD_W'(x3);
    it.ctrl_y3 = COORD_W'(y3);
    it.param_t = T_W'(t);
    return it;
  endfunction

  // Full range, a small range near zero (rounding ties), or the extremes
  function automatic cbpe_coord_t rand_coord(input int flavor);
    if (flavor == 0) return COORD_W'($urandom);
    if (flavor == 1) return COORD_W'($urandom_range(0, 128) - 64);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Random curves, each swept over a run of t values
  task automatic run_curves(input int count, input int idle_pct);
    cbpe_in_t it;
    int sent;
    int flavor;
    int len;
    int r;
    int unsigned k;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 9);
      flavor = (r < 6) ? 0 : (r < 9) ? 1 : 2;
      it.ctrl_x0 = rand_coord(flavor);
      it.ctrl_y0 = rand_coord(flavor);
      it.ctrl_x1 = rand_coord(flavor);
      it.ctrl_y1 = rand_coord(flavor);
      it.ctrl_x2 = rand_coord(flavor);
      it.ctrl_y2 = rand_coord(flavor);
      it.ctrl_x3 = rand_coord(flavor);
      it.ctrl_y3 = rand_coord(flavor);
      len = $urandom_range(1, 16);
      k = $urandom_range(0, 100);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // Advance along the 0.01 sweep
          it.param_t = T_W'((k * 32'(T_ONE) + 50) / 100);
          k = (k + 1) % 101;
        end else if (r < 85) begin
          it.param_t = T_W'($urandom_range(0, 32'(T_ONE)));
        end else if (r < 93) begin
          it.param_t = T_W'($urandom_range(32'(T_ONE) + 1, (1 << T_W) - 1));
        end else begin
          case ($urandom_range(0, 3))
            0: it.param_t = '0;
            1: it.param_t = T_W'(1);
            2: it.param_t = T_ONE - T_W'(1);
            default: it.param_t = T_ONE;
          endcase
        end
        send_item(it, idle_pct);
        sent++;
      end
    end
  endtask

  initial begin
    cbpe_in_t dir_items[$];
    int       tv [10];
    // Apply reset, then release it
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: endpoints, extremes of the hull, t above one, rounding ties
    dir_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_items.push_back(make_item(-32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768, 0));
    dir_items.push_back(make_item(-32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768, 65536));
    dir_items.push_back(make_item(-32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768, 32768));
    dir_items.push_back(make_item(32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767, 32768));
    tv = '{0, 1, 32768, 65535, 65536, 65537, 98304, 131071, 655, 64881};
    foreach (tv[i]) begin
      dir_items.push_back(make_item(-32768, 32767, 32767, -32768,
                                    -32768, 32767, 32767, -32768, tv[i]));
    end
    // Quarter t gives weights in 64ths: exact halves round toward +infinity
    dir_items.push_back(make_item(0, 0, 0, 0, 0, 0, 2, -2, 16384));
    dir_items.push_back(make_item(0, 0, 0, 0, 0, 0, 6, -6, 16384));
    dir_items.push_back(make_item(0, 0, 0, 0, 0, 0, -1, 1, 16384));
    foreach (dir_items[i]) send_item(dir_items[i], 30);

    // Random curves: idle 30 of 100, then 65 of 100, then back to back
    run_curves(450, 30);
    run_curves(450, 65);
    run_curves(450, 0);

    // Drain the pipe, then allow for any stray strobe
    start <= 1'b0;
    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Ran %0d transactions (%0d directed, rest random curves swept in t),",
             board.noted, dir_items.size());
    $display("checked %0d curve points across three idle profiles.", board.checked);
    if (board.errors == 0 && board.pending_points.size() == 0) begin
      $display("cubic_bezier_point_eval_tb: clean");
    end else begin
      $display("cubic_bezier_point_eval_tb: errors");
    end
    $finish;
  end

endmodule

// ===== cubic_bezier_point_eval.f =====
hw/rtl/cbpe_pkg.sv
hw/rtl/cbpe_weight.sv
hw/rtl/cbpe_axis.sv
hw/rtl/cubic_bezier_point_eval.sv
test/cubic_bezier_point_eval_tb.sv
